// ===== rtl/core/scfh_pkg.sv =====
// shared types, constants and functions of the slave command frame handler
`default_nettype none
package scfh_pkg;

   localparam int MAX_FRAME_DEF   = 256;
   localparam int PARAM_BYTES_DEF = 18;
   localparam int XW              = 12;
   localparam int OUTQ_DEPTH      = 4;

   localparam logic [2:0] CSR_NODE_ADDR = 3'd0;
   localparam logic [7:0] NODE_ADDR_RST = 8'h01;

   localparam logic [7:0] BCAST_ADDR = 8'h00;
   localparam logic [7:0] NEG_FUNC   = 8'h80;
   localparam logic [7:0] STAT_COUNT = 8'd10;

   localparam logic [7:0] NEG_BAD_FUNC = 8'd0;
   localparam logic [7:0] NEG_BAD_CRC  = 8'd1;
   localparam logic [7:0] NEG_SHORT    = 8'd2;
   localparam logic [7:0] NEG_LENGTH   = 8'd3;

   // node function codes
   localparam logic [7:0] FN_STATUS      = 8'd0;
   localparam logic [7:0] FN_WIND        = 8'd1;
   localparam logic [7:0] FN_LOWER       = 8'd2;
   localparam logic [7:0] FN_STOP        = 8'd3;
   localparam logic [7:0] FN_GOTO        = 8'd4;
   localparam logic [7:0] FN_OWN_DL      = 8'd5;
   localparam logic [7:0] FN_READ_COMMON = 8'd6;
   localparam logic [7:0] FN_READ_OWN    = 8'd7;

   // broadcast and group function codes
   localparam logic [7:0] BF_STOP      = 8'd2;
   localparam logic [7:0] GF_GOTO      = 8'd3;
   localparam logic [7:0] GF_WIND      = 8'd4;
   localparam logic [7:0] GF_LOWER     = 8'd5;
   localparam logic [7:0] GF_STOP      = 8'd6;
   localparam logic [7:0] GF_COMMON_DL = 8'd7;

   localparam logic [2:0] CMD_WIND_UP     = 3'd0;
   localparam logic [2:0] CMD_LOWER       = 3'd1;
   localparam logic [2:0] CMD_STOP        = 3'd2;
   localparam logic [2:0] CMD_GOTO        = 3'd3;
   localparam logic [2:0] CMD_COMMON_DL   = 3'd4;
   localparam logic [2:0] CMD_OWN_DL      = 3'd5;
   localparam logic [2:0] CMD_READ_COMMON = 3'd6;
   localparam logic [2:0] CMD_READ_OWN    = 3'd7;

   localparam logic signed [11:0] TEMP_HIGH   = 12'sd700;
   localparam logic signed [11:0] TEMP_LOW    = -12'sd400;
   localparam logic [13:0]        SUPPLY_HIGH = 14'd6000;
   localparam logic [13:0]        SUPPLY_LOW  = 14'd4000;
   localparam logic [7:0]         INV_BELOW_ZERO = 8'h01;

   localparam logic [7:0] INV_CODES [16] = '{
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h09,
      8'h13, 8'h0C, 8'h0A, 8'h0B, 8'h14, 8'h1A, 8'h1C, 8'h1E};

   typedef struct packed {
      logic          over;
      logic [XW-1:0] flen;
   } job_type;

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] speed;
      logic [47:0] fault;
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic        last;
      logic [2:0]  cmd;
      logic [15:0] position;
      logic [15:0] speed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HDR, ST_CRC, ST_DECIDE, ST_SCAN,
      ST_LOCATE, ST_FETCH, ST_APPLY, ST_EVENT, ST_REPLY
   } back_state_type;

   typedef enum logic [2:0] {
      RK_NONE, RK_POS, RK_NEG, RK_STAT, RK_READ
   } reply_kind_type;

   typedef enum logic [2:0] {
      GOP_NONE, GOP_SPD_HDR, GOP_PAR_HDR, GOP_ZERO_HDR, GOP_HDR_W, GOP_W4, GOP_W2
   } goal_op_type;

   typedef struct packed {
      back_state_type next;
      logic           ev;
      logic [2:0]     cmd;
      reply_kind_type rk;
      logic [7:0]     rarg;
      goal_op_type    gop;
      logic [XW-1:0]  fbase;
      logic [XW-1:0]  fnum;
      logic           fpar;
   } plan_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scfh_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module scfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/scfh_front.sv =====
// front end: takes words, buffers frame bytes, keeps status samples, hands over frames
`default_nettype none
module scfh_front #(
   parameter int MAX_FRAME = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_type,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_rx_last,
   input  logic [15:0]                   req_cur_position,
   input  logic [15:0]                   req_cur_speed,
   input  logic [8:0]                    req_digital_inputs,
   input  logic signed [11:0]            req_env_temp_tenths,
   input  logic [13:0]                   req_supply_mv,
   input  logic [7:0]                    req_inverter_fault,
   output logic                          ram_we,
   output logic [$clog2(MAX_FRAME)-1:0]  ram_waddr,
   output logic [7:0]                    ram_wdata,
   output logic                          job_valid,
   output scfh_pkg::job_type             job,
   input  logic                          job_take,
   input  logic                          back_busy,
   output scfh_pkg::status_type          status
);
   import scfh_pkg::*;

   localparam int CW = $clog2(MAX_FRAME + 2);
   localparam int AW = $clog2(MAX_FRAME);

   logic [CW-1:0] count_ff, count_in;
   logic          jv_ff, jv_in;
   job_type       job_ff, job_in;
   status_type    stat_ff, stat_in;
   logic          accept;
   logic          over;
   logic [47:0]   fault;

   assign full      = jv_ff || back_busy;
   assign accept    = push && !full;
   assign over      = count_ff >= CW'(MAX_FRAME);
   assign ram_we    = accept && !req_type && (count_ff < CW'(MAX_FRAME));
   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = req_rx_byte;
   assign job_valid = jv_ff;
   assign job       = job_ff;
   assign status    = stat_ff;

   always_comb begin
      fault        = '0;
      fault[5:0]   = req_digital_inputs[5:0];
      fault[18:16] = req_digital_inputs[8:6];
      fault[19]    = req_env_temp_tenths > TEMP_HIGH;
      fault[20]    = req_env_temp_tenths < TEMP_LOW;
      fault[21]    = req_supply_mv > SUPPLY_HIGH;
      fault[22]    = req_supply_mv < SUPPLY_LOW;
      for (int i = 0; i < 16; i++) begin
         fault[23+i] = req_inverter_fault == INV_CODES[i];
      end
      fault[39]    = req_inverter_fault == INV_BELOW_ZERO;
   end

   always_comb begin
      count_in = count_ff;
      jv_in    = jv_ff && !job_take;
      job_in   = job_ff;
      stat_in  = stat_ff;
      if (accept && req_type) begin
         stat_in.position = req_cur_position;
         stat_in.speed    = req_cur_speed;
         stat_in.fault    = fault;
      end
      if (accept && !req_type) begin
         if (count_ff <= CW'(MAX_FRAME)) begin
            count_in = count_ff + CW'(1);
         end
         if (req_rx_last) begin
            jv_in       = 1'b1;
            job_in.over = over;
            job_in.flen = over ? XW'(MAX_FRAME) : XW'(count_ff + CW'(1));
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         count_ff <= '0;
         jv_ff    <= 1'b0;
         stat_ff  <= '0;
      end else begin
         count_ff <= count_in;
         jv_ff    <= jv_in;
         stat_ff  <= stat_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/scfh_back.sv =====
// back end: reads a buffered frame, checks it, applies commands and builds replies
`default_nettype none
module scfh_back #(
   parameter int MAX_FRAME   = 256,
   parameter int PARAM_BYTES = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  scfh_pkg::job_type             job,
   output logic                          job_take,
   output logic                          busy,
   input  logic [7:0]                    node_address,
   input  scfh_pkg::status_type          status,
   output logic [$clog2(MAX_FRAME)-1:0]  ram_raddr,
   input  logic [7:0]                    ram_rdata,
   output logic                          q_push,
   output scfh_pkg::rsp_type             q_data,
   input  logic                          q_full
);
   import scfh_pkg::*;

   localparam int LW = $clog2(MAX_FRAME + 1);
   localparam int AW = $clog2(MAX_FRAME);
   localparam int RW = $clog2(PARAM_BYTES + 6);

   back_state_type state_ff, state_in;
   logic [XW-1:0]  cnt_ff, cnt_in, base_ff, base_in, num_ff, num_in, pidx_ff;
   logic           pend_ff, inr_ff;
   logic [LW-1:0]  flen_ff, flen_in;
   logic           over_ff, over_in;
   logic [7:0]     hb_ff [5];
   logic [7:0]     hb_in [5];
   logic [7:0]     w_ff [4];
   logic [7:0]     w_in [4];
   logic [7:0]     par_ff [PARAM_BYTES];
   logic [7:0]     par_in [PARAM_BYTES];
   logic [15:0]    crc_ff, crc_in, rxcrc_ff, rxcrc_in, rcrc_ff, rcrc_in;
   logic           fnd_ff, fnd_in;
   logic [7:0]     fidx_ff, fidx_in;
   logic [15:0]    gpos_ff, gpos_in, gspd_ff, gspd_in;
   plan_type       plan_ff, plan_in, dec, loc, pl;
   logic [RW-1:0]  ridx_ff, ridx_in, rlen, k7, k3;
   logic           reading, rd_issue, done, crc_ok;
   logic [XW-1:0]  rd_addr;
   logic [7:0]     rbyte, body;
   logic [16:0]    flen17, want, want2;
   logic           fixed4, good;

   assign reading  = (state_ff == ST_HDR) || (state_ff == ST_CRC) ||
                     (state_ff == ST_SCAN) || (state_ff == ST_FETCH);
   assign rd_issue = reading && (cnt_ff < num_ff);
   assign rd_addr  = base_ff + cnt_ff;
   assign done     = (cnt_ff == num_ff) && !pend_ff;
   assign rbyte    = inr_ff ? ram_rdata : 8'h00;
   assign crc_ok   = (flen_ff >= LW'(4)) && (crc_ff == rxcrc_ff);
   assign flen17   = 17'(flen_ff);
   assign pl       = (state_ff == ST_LOCATE) ? loc : dec;

   // frame decision after header and check pass
   always_comb begin
      dec    = '{next: ST_IDLE, ev: 1'b0, cmd: CMD_WIND_UP, rk: RK_NONE, rarg: 8'h00,
                 gop: GOP_NONE, fbase: '0, fnum: '0, fpar: 1'b0};
      fixed4 = (hb_ff[1] == FN_STATUS) || (hb_ff[1] == FN_STOP) ||
               (hb_ff[1] == FN_READ_COMMON) || (hb_ff[1] == FN_READ_OWN);
      want   = '0;
      want2  = {1'b0, hb_ff[2], hb_ff[3]} + 17'd6;
      good   = 1'b0;
      if (!over_ff && (flen_ff < LW'(4))) begin
         if (hb_ff[0] == node_address) begin
            dec.next = ST_APPLY;
            dec.rk   = RK_NEG;
            dec.rarg = NEG_SHORT;
         end
      end else if (hb_ff[0] == BCAST_ADDR) begin
         if (hb_ff[1] <= BF_STOP) begin
            want = (hb_ff[1] == BF_STOP) ? 17'd4 : 17'(hb_ff[2]) + 17'd5;
            if (!over_ff && (flen17 == want) && crc_ok) begin
               dec.next = ST_APPLY;
               dec.ev   = 1'b1;
               dec.cmd  = hb_ff[1][2:0];
               dec.gop  = (hb_ff[1] != BF_STOP) ? GOP_SPD_HDR : GOP_NONE;
            end
         end else if (hb_ff[1] <= GF_COMMON_DL) begin
            if (!over_ff && (flen17 == want2)) begin
               if (hb_ff[1] == GF_COMMON_DL) begin
                  if (crc_ok) begin
                     dec.next = ST_APPLY;
                     dec.ev   = 1'b1;
                     dec.cmd  = CMD_COMMON_DL;
                  end
               end else begin
                  dec.next  = ST_SCAN;
                  dec.fbase = XW'(5);
                  dec.fnum  = XW'(hb_ff[4]);
               end
            end
         end
      end else if (hb_ff[0] == node_address) begin
         dec.next = ST_APPLY;
         if (hb_ff[1] > FN_READ_OWN) begin
            dec.rk   = RK_NEG;
            dec.rarg = NEG_BAD_FUNC;
         end else begin
            want = fixed4 ? 17'd4 : 17'(hb_ff[2]) + 17'd5;
            good = !over_ff && (flen17 == want);
            if ((hb_ff[1] == FN_WIND) || (hb_ff[1] == FN_LOWER)) begin
               good = good && (hb_ff[2] == 8'd2);
            end
            if (hb_ff[1] == FN_GOTO) begin
               good = good && (hb_ff[2] == 8'd4);
            end
            if (!good) begin
               dec.rk   = RK_NEG;
               dec.rarg = (!over_ff && (flen17 < want)) ? NEG_SHORT : NEG_LENGTH;
            end else if (!crc_ok) begin
               dec.rk   = RK_NEG;
               dec.rarg = NEG_BAD_CRC;
            end else begin
               dec.rarg = hb_ff[1];
               case (hb_ff[1])
                  FN_STATUS: begin
                     dec.rk = RK_STAT;
                  end
                  FN_WIND: begin
                     dec.ev  = 1'b1;
                     dec.cmd = CMD_WIND_UP;
                     dec.gop = GOP_PAR_HDR;
                     dec.rk  = RK_POS;
                  end
                  FN_LOWER: begin
                     dec.ev  = 1'b1;
                     dec.cmd = CMD_LOWER;
                     dec.gop = GOP_ZERO_HDR;
                     dec.rk  = RK_POS;
                  end
                  FN_STOP: begin
                     dec.ev  = 1'b1;
                     dec.cmd = CMD_STOP;
                     dec.rk  = RK_POS;
                  end
                  FN_GOTO: begin
                     dec.next  = ST_FETCH;
                     dec.ev    = 1'b1;
                     dec.cmd   = CMD_GOTO;
                     dec.gop   = GOP_HDR_W;
                     dec.rk    = RK_POS;
                     dec.fbase = XW'(5);
                     dec.fnum  = XW'(2);
                  end
                  FN_OWN_DL: begin
                     dec.next  = ST_FETCH;
                     dec.ev    = 1'b1;
                     dec.cmd   = CMD_OWN_DL;
                     dec.rk    = RK_POS;
                     dec.fbase = XW'(3);
                     dec.fnum  = XW'(PARAM_BYTES);
                     dec.fpar  = 1'b1;
                  end
                  FN_READ_COMMON: begin
                     dec.ev  = 1'b1;
                     dec.cmd = CMD_READ_COMMON;
                  end
                  default: begin
                     dec.ev  = 1'b1;
                     dec.cmd = CMD_READ_OWN;
                     dec.rk  = RK_READ;
                  end
               endcase
            end
         end
      end
   end

   // group frame outcome once the member list has been searched
   always_comb begin
      loc = '{next: ST_IDLE, ev: 1'b0, cmd: CMD_WIND_UP, rk: RK_NONE, rarg: 8'h00,
              gop: GOP_NONE, fbase: '0, fnum: '0, fpar: 1'b0};
      if (fnd_ff && crc_ok) begin
         loc.ev = 1'b1;
         case (hb_ff[1])
            GF_GOTO: begin
               loc.next  = ST_FETCH;
               loc.cmd   = CMD_GOTO;
               loc.gop   = GOP_W4;
               loc.fbase = XW'(5) + XW'(hb_ff[4]) + (XW'(fidx_ff) << 2);
               loc.fnum  = XW'(4);
            end
            GF_WIND, GF_LOWER: begin
               loc.next  = ST_FETCH;
               loc.cmd   = (hb_ff[1] == GF_WIND) ? CMD_WIND_UP : CMD_LOWER;
               loc.gop   = GOP_W2;
               loc.fbase = XW'(5) + XW'(hb_ff[4]) + (XW'(fidx_ff) << 1);
               loc.fnum  = XW'(2);
            end
            default: begin
               loc.next = ST_APPLY;
               loc.cmd  = CMD_STOP;
            end
         endcase
      end
   end

   always_comb begin
      case (plan_ff.rk)
         RK_POS:  rlen = RW'(2);
         RK_NEG:  rlen = RW'(3);
         RK_STAT: rlen = RW'(13);
         RK_READ: rlen = RW'(PARAM_BYTES + 3);
         default: rlen = '0;
      endcase
      k7   = ridx_ff - RW'(7);
      k3   = ridx_ff - RW'(3);
      body = 8'h00;
      case (plan_ff.rk)
         RK_POS: begin
            body = (ridx_ff == RW'(0)) ? node_address : plan_ff.rarg;
         end
         RK_NEG: begin
            case (ridx_ff)
               RW'(0):  body = node_address;
               RW'(1):  body = NEG_FUNC;
               default: body = plan_ff.rarg;
            endcase
         end
         RK_STAT: begin
            case (ridx_ff)
               RW'(0):  body = hb_ff[0];
               RW'(1):  body = hb_ff[1];
               RW'(2):  body = STAT_COUNT;
               RW'(3):  body = status.position[15:8];
               RW'(4):  body = status.position[7:0];
               RW'(5):  body = status.speed[15:8];
               RW'(6):  body = status.speed[7:0];
               default: begin
                  for (int i = 0; i < 6; i++) begin
                     if (k7 == RW'(i)) begin
                        body = status.fault[8*i +: 8];
                     end
                  end
               end
            endcase
         end
         RK_READ: begin
            case (ridx_ff)
               RW'(0):  body = node_address;
               RW'(1):  body = FN_READ_OWN;
               RW'(2):  body = 8'(PARAM_BYTES);
               default: begin
                  for (int i = 0; i < PARAM_BYTES; i++) begin
                     if (k3 == RW'(i)) begin
                        body = par_ff[i];
                     end
                  end
               end
            endcase
         end
         default: body = 8'h00;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (job_valid) state_in = ST_HDR;
         ST_HDR:    if (done) state_in = ST_CRC;
         ST_CRC:    if (done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = dec.next;
         ST_SCAN:   if (done) state_in = ST_LOCATE;
         ST_LOCATE: state_in = loc.next;
         ST_FETCH:  if (done) state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_EVENT;
         ST_EVENT: begin
            if (!plan_ff.ev || !q_full) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (plan_ff.rk == RK_NONE) begin
               state_in = ST_IDLE;
            end else if (!q_full && (ridx_ff == rlen + RW'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_take         = (state_ff == ST_IDLE) && job_valid;
      busy             = state_ff != ST_IDLE;
      ram_raddr        = rd_addr[AW-1:0];
      q_push           = 1'b0;
      q_data.kind      = 1'b0;
      q_data.data      = 8'h00;
      q_data.last      = 1'b0;
      q_data.cmd       = CMD_WIND_UP;
      q_data.position  = gpos_ff;
      q_data.speed     = gspd_ff;
      case (state_ff)
         ST_EVENT: begin
            q_push      = plan_ff.ev && !q_full;
            q_data.kind = 1'b1;
            q_data.last = 1'b1;
            q_data.cmd  = plan_ff.cmd;
         end
         ST_REPLY: begin
            q_push      = (plan_ff.rk != RK_NONE) && !q_full;
            q_data.last = ridx_ff == rlen + RW'(1);
            if (ridx_ff < rlen) begin
               q_data.data = body;
            end else if (ridx_ff == rlen) begin
               q_data.data = rcrc_ff[7:0];
            end else begin
               q_data.data = rcrc_ff[15:8];
            end
         end
         default: q_push = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in   = reading ? (done ? '0 : (rd_issue ? cnt_ff + XW'(1) : cnt_ff)) : '0;
      base_in  = base_ff;
      num_in   = num_ff;
      flen_in  = flen_ff;
      over_in  = over_ff;
      hb_in    = hb_ff;
      w_in     = w_ff;
      par_in   = par_ff;
      crc_in   = crc_ff;
      rxcrc_in = rxcrc_ff;
      rcrc_in  = rcrc_ff;
      fnd_in   = fnd_ff;
      fidx_in  = fidx_ff;
      gpos_in  = gpos_ff;
      gspd_in  = gspd_ff;
      plan_in  = plan_ff;
      ridx_in  = ridx_ff;
      case (state_ff)
         ST_IDLE: begin
            flen_in = job.flen[LW-1:0];
            over_in = job.over;
            base_in = '0;
            num_in  = XW'(5);
            crc_in  = 16'hFFFF;
            fnd_in  = 1'b0;
         end
         ST_HDR: begin
            if (pend_ff) begin
               for (int i = 0; i < 5; i++) begin
                  if (pidx_ff == XW'(i)) hb_in[i] = rbyte;
               end
            end
            if (done) begin
               base_in = '0;
               num_in  = XW'(flen_ff);
            end
         end
         ST_CRC: begin
            if (pend_ff) begin
               if (pidx_ff + XW'(2) < XW'(flen_ff)) begin
                  crc_in = crc_step(crc_ff, rbyte);
               end else if (pidx_ff + XW'(2) == XW'(flen_ff)) begin
                  rxcrc_in[7:0] = rbyte;
               end else begin
                  rxcrc_in[15:8] = rbyte;
               end
            end
         end
         ST_DECIDE, ST_LOCATE: begin
            plan_in = pl;
            base_in = pl.fbase;
            num_in  = pl.fnum;
         end
         ST_SCAN: begin
            if (pend_ff && !fnd_ff && (rbyte == node_address)) begin
               fnd_in  = 1'b1;
               fidx_in = pidx_ff[7:0];
            end
         end
         ST_FETCH: begin
            if (pend_ff) begin
               for (int i = 0; i < 4; i++) begin
                  if (pidx_ff == XW'(i)) w_in[i] = rbyte;
               end
               if (plan_ff.fpar) begin
                  for (int i = 0; i < PARAM_BYTES; i++) begin
                     if (pidx_ff == XW'(i)) par_in[i] = rbyte;
                  end
               end
            end
         end
         ST_APPLY: begin
            ridx_in = '0;
            rcrc_in = 16'hFFFF;
            case (plan_ff.gop)
               GOP_SPD_HDR: gspd_in = {hb_ff[3], hb_ff[4]};
               GOP_PAR_HDR: begin
                  gpos_in = {par_ff[12], par_ff[13]};
                  gspd_in = {hb_ff[3], hb_ff[4]};
               end
               GOP_ZERO_HDR: begin
                  gpos_in = '0;
                  gspd_in = {hb_ff[3], hb_ff[4]};
               end
               GOP_HDR_W: begin
                  gpos_in = {hb_ff[3], hb_ff[4]};
                  gspd_in = {w_ff[0], w_ff[1]};
               end
               GOP_W4: begin
                  gpos_in = {w_ff[0], w_ff[1]};
                  gspd_in = {w_ff[2], w_ff[3]};
               end
               GOP_W2:  gspd_in = {w_ff[0], w_ff[1]};
               default: gspd_in = gspd_ff;
            endcase
         end
         ST_REPLY: begin
            if (q_push) begin
               ridx_in = ridx_ff + RW'(1);
               if (ridx_ff < rlen) rcrc_in = crc_step(rcrc_ff, body);
            end
         end
         default: ridx_in = ridx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      num_ff   <= num_in;
      pidx_ff  <= cnt_ff;
      inr_ff   <= rd_addr < XW'(flen_ff);
      flen_ff  <= flen_in;
      over_ff  <= over_in;
      hb_ff    <= hb_in;
      w_ff     <= w_in;
      crc_ff   <= crc_in;
      rxcrc_ff <= rxcrc_in;
      rcrc_ff  <= rcrc_in;
      fidx_ff  <= fidx_in;
      plan_ff  <= plan_in;
      ridx_ff  <= ridx_in;
      fnd_ff   <= fnd_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         gpos_ff  <= '0;
         gspd_ff  <= '0;
         for (int i = 0; i < PARAM_BYTES; i++) par_ff[i] <= 8'h00;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= rd_issue;
         gpos_ff  <= gpos_in;
         gspd_ff  <= gspd_in;
         par_ff   <= par_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/scfh_outq.sv =====
// small result queue between the back end and the result ports
`default_nettype none
module scfh_outq #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scfh_pkg::rsp_type din,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output scfh_pkg::rsp_type dout
);
   import scfh_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type       ent_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign dout    = ent_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = do_push ? ((wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1)) : wp_ff;
      rp_in  = do_pop ? ((rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1)) : rp_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= din;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/slave_command_frame_handler.sv =====
// top level of the slave command frame handler
// A frame byte or a status sample is taken while full is low. At the word that closes a
// frame, full stays high while the frame is handled out of the frame memory, which has a
// single write port: a header pass, a CRC pass and the decision, for a group frame a member
// search, payload reads, the command word and the reply words (up to PARAM_BYTES + 5);
// this takes longer when the four-word result queue backs up.
`default_nettype none
module slave_command_frame_handler #(
   parameter int MAX_FRAME   = scfh_pkg::MAX_FRAME_DEF,
   parameter int PARAM_BYTES = scfh_pkg::PARAM_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_type,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_rx_last,
   input  logic [15:0]        req_cur_position,
   input  logic [15:0]        req_cur_speed,
   input  logic [8:0]         req_digital_inputs,
   input  logic signed [11:0] req_env_temp_tenths,
   input  logic [13:0]        req_supply_mv,
   input  logic [7:0]         req_inverter_fault,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_out_kind,
   output logic [7:0]         rsp_resp_byte,
   output logic               rsp_resp_last,
   output logic [2:0]         rsp_command,
   output logic [15:0]        rsp_target_position,
   output logic [15:0]        rsp_target_speed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import scfh_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);

   logic [7:0]    node_ff, node_in;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          job_valid, job_take, back_busy;
   job_type       job;
   status_type    status;
   logic          q_push, q_full;
   rsp_type       q_data, q_head;

   assign pready  = 1'b1;
   assign prdata  = (paddr == CSR_NODE_ADDR) ? {24'd0, node_ff} : 32'd0;
   assign node_in = (psel && penable && pwrite && (paddr == CSR_NODE_ADDR)) ?
                    pwdata[7:0] : node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= NODE_ADDR_RST;
      end else begin
         node_ff <= node_in;
      end
   end

   scfh_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock, .reset, .push, .full,
      .req_type, .req_rx_byte, .req_rx_last, .req_cur_position, .req_cur_speed,
      .req_digital_inputs, .req_env_temp_tenths, .req_supply_mv, .req_inverter_fault,
      .ram_we, .ram_waddr, .ram_wdata,
      .job_valid, .job, .job_take, .back_busy, .status
   );

   scfh_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame_ram (
      .clock, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   scfh_back #(.MAX_FRAME(MAX_FRAME), .PARAM_BYTES(PARAM_BYTES)) u_back (
      .clock, .reset, .job_valid, .job, .job_take, .busy(back_busy),
      .node_address(node_ff), .status,
      .ram_raddr, .ram_rdata,
      .q_push, .q_data, .q_full
   );

   scfh_outq #(.DEPTH(OUTQ_DEPTH)) u_outq (
      .clock, .reset, .push(q_push), .din(q_data), .full(q_full),
      .pop, .empty, .dout(q_head)
   );

   assign rsp_out_kind        = q_head.kind;
   assign rsp_resp_byte       = q_head.data;
   assign rsp_resp_last       = q_head.last;
   assign rsp_command         = q_head.cmd;
   assign rsp_target_position = q_head.position;
   assign rsp_target_speed    = q_head.speed;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("result pushed into a full queue");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (!back_busy && !job_valid))
      else $error("frame memory written while a frame is handled");

   a_job_starts: assert property (@(posedge clock) disable iff (reset)
      job_take |=> (back_busy && !job_valid))
      else $error("frame handover did not start the back end");
endmodule
`default_nettype wire
